[rtl/core/asd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asd_pkg: shared types and constants of the accelerometer step detector
// Field widths, register codes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package asd_pkg;

    localparam int DAY_W   = 32;
    localparam int TIME_W  = 63;
    localparam int COUNT_W = 32;
    localparam int LEVEL_W = 32;
    localparam int SHIFT_W = 4;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LEVEL_W-1:0] TRIGGER_RESET    = 32'd2600;
    localparam logic [LEVEL_W-1:0] RELEASE_RESET    = 32'd900;
    localparam logic [LEVEL_W-1:0] MIN_GAP_RESET    = 32'd350000;
    localparam logic [SHIFT_W-1:0] FAST_SHIFT_RESET = 4'd2;
    localparam logic [SHIFT_W-1:0] SLOW_SHIFT_RESET = 4'd5;

    // Register index, taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_TRIGGER    = 3'd0,
        REG_RELEASE    = 3'd1,
        REG_MIN_GAP    = 3'd2,
        REG_FAST_SHIFT = 3'd3,
        REG_SLOW_SHIFT = 3'd4
    } asd_reg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] trigger_level;
        logic [LEVEL_W-1:0] release_level;
        logic [LEVEL_W-1:0] min_gap_us;
        logic [SHIFT_W-1:0] fast_shift;
        logic [SHIFT_W-1:0] slow_shift;
    } asd_cfg_t;

endpackage
`default_nettype wire

[rtl/core/asd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asd_front: input stage of the step detector
// Accepts a sample beat, registers the three axis squares and pushes the
// magnitude, day key and timestamp into the queue.
// ----------------------------------------------------------------------------
module asd_front
    import asd_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int MAG_W       = 2 * SAMPLE_BITS,
    parameter int ITEM_W      = MAG_W + DAY_W + TIME_W
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [15:0]       accel_x,
    input  wire logic [15:0]       accel_y,
    input  wire logic [15:0]       accel_z,
    input  wire logic [DAY_W-1:0]  day_key,
    input  wire logic [TIME_W-1:0] time_us,
    output logic                   push,
    output logic [ITEM_W-1:0]      push_data,
    input  wire logic              full
);

    logic                    valid_reg;
    logic                    valid_next;
    logic [MAG_W-1:0]        sq_x_reg;
    logic [MAG_W-1:0]        sq_y_reg;
    logic [MAG_W-1:0]        sq_z_reg;
    logic [DAY_W-1:0]        day_reg;
    logic [TIME_W-1:0]       time_reg;
    logic signed [MAG_W-1:0] wide_x;
    logic signed [MAG_W-1:0] wide_y;
    logic signed [MAG_W-1:0] wide_z;
    logic                    load;
    logic [MAG_W-1:0]        mag;

    // Only the low SAMPLE_BITS bits of each axis count; they are sign extended.
    assign wide_x = MAG_W'($signed(accel_x[SAMPLE_BITS-1:0]));
    assign wide_y = MAG_W'($signed(accel_y[SAMPLE_BITS-1:0]));
    assign wide_z = MAG_W'($signed(accel_z[SAMPLE_BITS-1:0]));

    assign push     = valid_reg && !full;
    assign load     = !valid_reg || push;
    assign in_stall = valid_reg && full;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            sq_x_reg <= MAG_W'(wide_x * wide_x);
            sq_y_reg <= MAG_W'(wide_y * wide_y);
            sq_z_reg <= MAG_W'(wide_z * wide_z);
            day_reg  <= day_key;
            time_reg <= time_us;
        end
    end

    // The sum of three squares stays below 2^MAG_W.
    assign mag       = sq_x_reg + sq_y_reg + sq_z_reg;
    assign push_data = {mag, day_reg, time_reg};

endmodule
`default_nettype wire

[rtl/core/asd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asd_queue: short register queue between front and back
// Holds decoded sample beats so that either side can stall on its own.
// ----------------------------------------------------------------------------
module asd_queue
    import asd_pkg::*;
#(
    parameter int ITEM_W = 127
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [ITEM_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic [ITEM_W-1:0]      pop_data,
    output logic                   empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [ITEM_W-1:0] data_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

[rtl/core/asd_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asd_back: filter and step decision of the step detector
// Updates the fast and slow averages, tests for a step and holds the result.
// ----------------------------------------------------------------------------
module asd_back
    import asd_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int MAG_W       = 2 * SAMPLE_BITS,
    parameter int ITEM_W      = MAG_W + DAY_W + TIME_W
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire asd_cfg_t           cfg,
    input  wire logic               empty,
    input  wire logic [ITEM_W-1:0]  pop_data,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [COUNT_W-1:0]      step_total,
    output logic [DAY_W-1:0]        current_day,
    output logic                    step_seen
);

    localparam int AVG_W = MAG_W + 2;
    localparam int SIG_W = AVG_W + 1;
    localparam int CMP_W = (SIG_W > LEVEL_W + 1) ? SIG_W : LEVEL_W + 1;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    step_seen_reg;
    logic [COUNT_W-1:0]      day_steps_reg;
    logic [COUNT_W-1:0]      day_steps_next;
    logic [DAY_W-1:0]        stored_day_reg;
    logic                    seeded_reg;
    logic                    peak_latched_reg;
    logic                    peak_latched_next;
    logic [TIME_W-1:0]       last_step_reg;
    logic [TIME_W-1:0]       last_step_next;
    logic signed [AVG_W-1:0] fast_avg_reg;
    logic signed [AVG_W-1:0] fast_avg_next;
    logic signed [AVG_W-1:0] slow_avg_reg;
    logic signed [AVG_W-1:0] slow_avg_next;

    logic [MAG_W-1:0]        item_mag;
    logic [DAY_W-1:0]        item_day;
    logic [TIME_W-1:0]       item_time;
    logic                    same_day;
    logic                    live_seeded;
    logic                    live_latched;
    logic [COUNT_W-1:0]      live_steps;
    logic [TIME_W-1:0]       live_last;
    logic signed [SIG_W-1:0] mag_s;
    logic signed [SIG_W-1:0] fast_diff;
    logic signed [SIG_W-1:0] slow_diff;
    logic signed [SIG_W-1:0] fast_sum;
    logic signed [SIG_W-1:0] slow_sum;
    logic signed [SIG_W-1:0] avg_spread;
    logic signed [CMP_W-1:0] signal_ext;
    logic signed [CMP_W-1:0] trigger_ext;
    logic signed [CMP_W-1:0] release_ext;
    logic signed [TIME_W:0]  elapsed;
    logic                    gap_ok;
    logic                    below_release;
    logic                    step_hit;

    assign {item_mag, item_day, item_time} = pop_data;

    assign pop = !empty && (!out_valid_reg || !out_stall);

    // A new day key clears the day's state before this sample is used.
    assign same_day     = (item_day == stored_day_reg);
    assign live_seeded  = same_day && seeded_reg;
    assign live_latched = same_day && peak_latched_reg;
    assign live_steps   = same_day ? day_steps_reg : '0;
    assign live_last    = same_day ? last_step_reg : '0;

    // The arithmetic shift rounds toward minus infinity.
    assign mag_s       = $signed({3'b000, item_mag});
    assign fast_diff   = mag_s - SIG_W'(fast_avg_reg);
    assign slow_diff   = mag_s - SIG_W'(slow_avg_reg);
    assign fast_sum    = SIG_W'(fast_avg_reg) + (fast_diff >>> cfg.fast_shift);
    assign slow_sum    = SIG_W'(slow_avg_reg) + (slow_diff >>> cfg.slow_shift);
    assign avg_spread  = fast_sum - slow_sum;

    assign signal_ext    = CMP_W'(avg_spread);
    assign trigger_ext   = $signed(CMP_W'(cfg.trigger_level));
    assign release_ext   = $signed(CMP_W'(cfg.release_level));
    assign below_release = (signal_ext < release_ext);

    // Both timestamps are non-negative, so the difference cannot overflow.
    assign elapsed = $signed({1'b0, item_time}) - $signed({1'b0, live_last});
    assign gap_ok  = (elapsed >= $signed((TIME_W + 1)'(cfg.min_gap_us)));

    assign step_hit = live_seeded && (signal_ext > trigger_ext) &&
                      !(live_latched && !below_release) && gap_ok;

    always_comb
    begin
        out_valid_next    = out_valid_reg;
        day_steps_next    = live_steps;
        last_step_next    = live_last;
        peak_latched_next = live_latched;
        fast_avg_next     = AVG_W'(fast_sum);
        slow_avg_next     = AVG_W'(slow_sum);
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (!live_seeded)
        begin
            fast_avg_next = $signed({2'b00, item_mag});
            slow_avg_next = $signed({2'b00, item_mag});
        end
        else
        begin
            if (below_release)
            begin
                peak_latched_next = 1'b0;
            end
            if (step_hit)
            begin
                day_steps_next    = live_steps + 1'b1;
                peak_latched_next = 1'b1;
                last_step_next    = item_time;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            day_steps_reg    <= '0;
            stored_day_reg   <= '0;
            seeded_reg       <= 1'b0;
            peak_latched_reg <= 1'b0;
            last_step_reg    <= '0;
            fast_avg_reg     <= '0;
            slow_avg_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                day_steps_reg    <= day_steps_next;
                stored_day_reg   <= item_day;
                seeded_reg       <= 1'b1;
                peak_latched_reg <= peak_latched_next;
                last_step_reg    <= last_step_next;
                fast_avg_reg     <= fast_avg_next;
                slow_avg_reg     <= slow_avg_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            step_seen_reg <= step_hit;
        end
    end

    // The day state changes only with a new result, so it doubles as output.
    assign out_valid   = out_valid_reg;
    assign step_total  = day_steps_reg;
    assign current_day = stored_day_reg;
    assign step_seen   = step_seen_reg;

    a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg)
        else $error("popped beat did not produce a result");

    a_step_sets_latch: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && step_hit) |=> (peak_latched_reg && seeded_reg && step_seen_reg))
        else $error("counted step left latch or seed flag clear");

    a_day_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !same_day) |=> (stored_day_reg == $past(item_day) &&
                                day_steps_reg == COUNT_W'(step_seen_reg)))
        else $error("day change did not restart the day count");

endmodule
`default_nettype wire

[rtl/core/accel_step_detector_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// accel_step_detector_unit: pedometer step detector, top level
// Squared magnitude, dual exponential averages and step counting per day.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat (in_valid high, in_stall low) carries one accelerometer
// sample: three signed axes, the day key and a microsecond timestamp. Each
// beat produces exactly one output beat on out_valid/out_stall with the
// day's step count, the day key it belongs to and a flag that is high when
// this sample counted a step.
// An accepted beat passes through the front stage, which loads the axis
// squares at the accepting edge, the two-entry queue and the result
// register in the back stage, whose load raises out_valid. Throughput is
// one beat per cycle while the receiver does not stall; the back stage
// does the whole per-sample state update as it loads the result register.
// When the receiver stalls, the result holds, the queue fills and in_stall
// rises once the queue is full; no beat is dropped.
// Reset clears the day state, the averages and the queue and loads the
// default thresholds. Configuration must be written over the APB port
// only while no beat is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module accel_step_detector_unit
    import asd_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [15:0]       accel_x,
    input  wire logic [15:0]       accel_y,
    input  wire logic [15:0]       accel_z,
    input  wire logic [DAY_W-1:0]  day_key,
    input  wire logic [TIME_W-1:0] time_us,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [COUNT_W-1:0]     step_total,
    output logic [DAY_W-1:0]       current_day,
    output logic                   step_seen,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    // The magnitude of three squares never reaches 2^(2*SAMPLE_BITS).
    localparam int MAG_W  = 2 * SAMPLE_BITS;
    localparam int ITEM_W = MAG_W + DAY_W + TIME_W;

    asd_cfg_t          cfg_reg;
    asd_cfg_t          cfg_next;
    asd_reg_t          reg_sel;
    logic              cfg_write;
    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    logic [ITEM_W-1:0] push_data;
    logic [ITEM_W-1:0] pop_data;

    // Register i sits at byte address 4*i; pready is tied high.
    assign pready    = 1'b1;
    assign reg_sel   = asd_reg_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_sel)
                REG_TRIGGER:    cfg_next.trigger_level = pwdata;
                REG_RELEASE:    cfg_next.release_level = pwdata;
                REG_MIN_GAP:    cfg_next.min_gap_us    = pwdata;
                REG_FAST_SHIFT: cfg_next.fast_shift    = pwdata[SHIFT_W-1:0];
                REG_SLOW_SHIFT: cfg_next.slow_shift    = pwdata[SHIFT_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_TRIGGER:    prdata = cfg_reg.trigger_level;
            REG_RELEASE:    prdata = cfg_reg.release_level;
            REG_MIN_GAP:    prdata = cfg_reg.min_gap_us;
            REG_FAST_SHIFT: prdata = DATA_W'(cfg_reg.fast_shift);
            REG_SLOW_SHIFT: prdata = DATA_W'(cfg_reg.slow_shift);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_level <= TRIGGER_RESET;
            cfg_reg.release_level <= RELEASE_RESET;
            cfg_reg.min_gap_us    <= MIN_GAP_RESET;
            cfg_reg.fast_shift    <= FAST_SHIFT_RESET;
            cfg_reg.slow_shift    <= SLOW_SHIFT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front stage: accepts samples and forms the squared magnitude.
    asd_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAG_W       (MAG_W),
        .ITEM_W      (ITEM_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .accel_z   (accel_z),
        .day_key   (day_key),
        .time_us   (time_us),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    // Queue: decouples the sample side from the result side.
    asd_queue #(
        .ITEM_W (ITEM_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    // Back stage: averages, step decision and the result register.
    asd_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAG_W       (MAG_W),
        .ITEM_W      (ITEM_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .empty       (empty),
        .pop_data    (pop_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .step_total  (step_total),
        .current_day (current_day),
        .step_seen   (step_seen)
    );

endmodule
`default_nettype wire

[bench/accel_step_detector_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_step_detector_unit_test: self-checking bench for the step detector
// Drives accelerometer samples with random gaps and receiver stalls, predicts
// every result beat with an independent pedometer model, and compares each
// result field by field. Thresholds and shifts are changed over APB between
// phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module accel_step_detector_unit_test
    import asd_pkg::*;
();

    // One input beat as the bench sees it.
    typedef struct {
        logic [15:0]       ax;
        logic [15:0]       ay;
        logic [15:0]       az;
        logic [DAY_W-1:0]  day;
        logic [TIME_W-1:0] stamp;
    } accel_sample_t;

    // One result beat: the running count, its day and the step flag.
    typedef struct {
        logic [COUNT_W-1:0] total;
        logic [DAY_W-1:0]   day;
        logic               seen;
    } step_report_t;

    // The scoreboard keeps its own copy of the thresholds and the day state.
    // Each accepted sample advances that state at once and queues the report
    // the block must produce for it; reports come back strictly in order.
    class pedometer_scoreboard;
        asd_cfg_t           cfg;
        logic [COUNT_W-1:0] day_steps;
        logic [DAY_W-1:0]   stored_day;
        bit                 seeded;
        bit                 peak_latched;
        longint             prev_step_stamp;
        longint             fast_avg;
        longint             slow_avg;
        step_report_t       reports_due[$];
        int                 errors;

        function new();
            errors = 0;
            cfg.trigger_level = TRIGGER_RESET;
            cfg.release_level = RELEASE_RESET;
            cfg.min_gap_us    = MIN_GAP_RESET;
            cfg.fast_shift    = FAST_SHIFT_RESET;
            cfg.slow_shift    = SLOW_SHIFT_RESET;
            clear_day('0);
        endfunction

        function void clear_day(logic [DAY_W-1:0] day);
            day_steps       = '0;
            stored_day      = day;
            seeded          = 1'b0;
            peak_latched    = 1'b0;
            prev_step_stamp = 0;
            fast_avg        = 0;
            slow_avg        = 0;
        endfunction

        function void write_reg(asd_reg_t idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_TRIGGER:    cfg.trigger_level = value;
                REG_RELEASE:    cfg.release_level = value;
                REG_MIN_GAP:    cfg.min_gap_us    = value;
                REG_FAST_SHIFT: cfg.fast_shift    = value[SHIFT_W-1:0];
                REG_SLOW_SHIFT: cfg.slow_shift    = value[SHIFT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(accel_sample_t s);
            longint       ax, ay, az, mag, signal, now, rel, trig, gap;
            step_report_t r;
            ax   = $signed(s.ax);
            ay   = $signed(s.ay);
            az   = $signed(s.az);
            now  = s.stamp;
            rel  = cfg.release_level;
            trig = cfg.trigger_level;
            gap  = cfg.min_gap_us;
            r.seen = 1'b0;

            if (s.day != stored_day)
                clear_day(s.day);

            mag = ax * ax + ay * ay + az * az;

            if (!seeded)
            begin
                // The first sample of a day only seeds both averages.
                fast_avg = mag;
                slow_avg = mag;
                seeded   = 1'b1;
            end
            else
            begin
                // Signed longint makes >>> round toward minus infinity.
                fast_avg = fast_avg + ((mag - fast_avg) >>> cfg.fast_shift);
                slow_avg = slow_avg + ((mag - slow_avg) >>> cfg.slow_shift);
                signal   = fast_avg - slow_avg;
                if (signal < rel)
                    peak_latched = 1'b0;
                if (signal > trig && !peak_latched && now - prev_step_stamp >= gap)
                begin
                    day_steps       = day_steps + 1'b1;
                    peak_latched    = 1'b1;
                    prev_step_stamp = now;
                    r.seen          = 1'b1;
                end
            end

            r.total = day_steps;
            r.day   = stored_day;
            reports_due.push_back(r);
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_report(logic [COUNT_W-1:0] total, logic [DAY_W-1:0] day,
                                   logic seen);
            step_report_t r;
            if (reports_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result beat with no sample waiting (total %0d, day %0d)",
                             $time, total, day);
                return;
            end
            r = reports_due.pop_front();
            compare_field("step_total", r.total, total);
            compare_field("current_day", r.day, day);
            compare_field("step_seen", r.seen, seen);
        endfunction

        function int pending();
            return reports_due.size();
        endfunction
    endclass

    // Clock, reset and every port of the block.
    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [15:0]        accel_x;
    logic [15:0]        accel_y;
    logic [15:0]        accel_z;
    logic [DAY_W-1:0]   day_key;
    logic [TIME_W-1:0]  time_us;
    logic               out_valid;
    logic               out_stall;
    logic [COUNT_W-1:0] step_total;
    logic [DAY_W-1:0]   current_day;
    logic               step_seen;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    pedometer_scoreboard board = new();

    // Shared between the sender and the receiver: quiet turns off all random
    // idling on both sides, hold_req asks the receiver for a long hold-off.
    bit quiet    = 1'b0;
    bit hold_req = 1'b0;

    // State of the synthetic walk that most random samples follow.
    logic [DAY_W-1:0]  walk_day    = '0;
    logic [TIME_W-1:0] walk_time   = '0;
    int                walk_amp    = 6000;
    int                stride_half = 6;
    int                stride_tick = 0;

    always #1 clk = ~clk;

    accel_step_detector_unit #(
        .SAMPLE_BITS (16)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .accel_x     (accel_x),
        .accel_y     (accel_y),
        .accel_z     (accel_z),
        .day_key     (day_key),
        .time_us     (time_us),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .step_total  (step_total),
        .current_day (current_day),
        .step_seen   (step_seen),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    function automatic accel_sample_t mk(int x, int y, int z, logic [DAY_W-1:0] day,
                                         logic [TIME_W-1:0] stamp);
        accel_sample_t s;
        s.ax    = 16'(x);
        s.ay    = 16'(y);
        s.az    = 16'(z);
        s.day   = day;
        s.stamp = stamp;
        return s;
    endfunction

    // Draws one full-scale axis value, often one of the edge values.
    function automatic logic [15:0] wild_axis();
        case ($urandom_range(5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Most samples follow a walk: a vertical axis that swings around a
    // gravity offset with a stride period and amplitude that change every
    // so often, and timestamps that move forward at a sensor-like rate.
    // The rest are day changes, timestamps that jump or go backward, and
    // full-scale noise.
    function automatic accel_sample_t next_sample();
        accel_sample_t s;
        int            roll;
        int            swing;
        roll = $urandom_range(99);
        stride_tick++;
        if (stride_tick % 64 == 0)
        begin
            walk_amp    = $urandom_range(0, 20000);
            stride_half = $urandom_range(2, 12);
        end

        if (roll == 0)
            walk_day = $urandom;
        else if (roll < 3)
            walk_day = walk_day + 1'b1;

        if (roll == 3)
            walk_time = TIME_W'({$urandom, $urandom});
        else if (roll == 4)
            walk_time = walk_time - TIME_W'($urandom_range(1, 500000));
        else
            walk_time = walk_time + TIME_W'($urandom_range(2000, 60000));

        if (roll >= 90)
        begin
            s.ax = wild_axis();
            s.ay = wild_axis();
            s.az = wild_axis();
        end
        else
        begin
            swing = ((stride_tick / stride_half) % 2) ? walk_amp : -walk_amp;
            s.ax  = 16'(int'($urandom_range(0, 2000)) - 1000);
            s.ay  = 16'(int'($urandom_range(0, 2000)) - 1000);
            s.az  = 16'(8000 + swing + int'($urandom_range(0, 800)) - 400);
        end
        s.day   = walk_day;
        s.stamp = walk_time;
        return s;
    endfunction

    // Offers one sample and returns at the edge that accepts it. Valid is
    // left high so that a following sample goes out back to back; callers
    // lower it through drop_valid when they pause.
    task automatic send_sample(accel_sample_t s);
        in_valid <= 1'b1;
        accel_x  <= s.ax;
        accel_y  <= s.ay;
        accel_z  <= s.az;
        day_key  <= s.day;
        time_us  <= s.stamp;
        do
            @(posedge clk);
        while (in_stall);
        board.note_sample(s);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random sender gaps, about one cycle in seven.
    task automatic sender_gaps();
        while (!quiet && $urandom_range(99) < 14)
            drop_valid();
    endtask

    // Stops offering samples until every queued report has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    // Setup cycle, then the access cycle; the register takes the value at
    // the edge where the access phase meets pready.
    task automatic apb_write(asd_reg_t idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_levels(logic [LEVEL_W-1:0] trig, logic [LEVEL_W-1:0] rel,
                              logic [LEVEL_W-1:0] gap, logic [SHIFT_W-1:0] fs,
                              logic [SHIFT_W-1:0] ss);
        wait_drained();
        apb_write(REG_TRIGGER, trig);
        apb_write(REG_RELEASE, rel);
        apb_write(REG_MIN_GAP, gap);
        apb_write(REG_FAST_SHIFT, DATA_W'(fs));
        apb_write(REG_SLOW_SHIFT, DATA_W'(ss));
    endtask

    // Directed samples under the reset thresholds: seeding, the largest and
    // smallest magnitudes, the gap rule, release followed by a new trigger,
    // time running backward, and day changes with edge-valued keys and
    // timestamps.
    task automatic run_directed();
        send_sample(mk(0, 0, 0, 32'd0, 63'd0));
        send_sample(mk(-32768, -32768, -32768, 32'd0, 63'd1000));
        send_sample(mk(32767, 32767, 32767, 32'd0, 63'd400000));
        send_sample(mk(0, 0, 0, 32'd0, 63'd800000));
        send_sample(mk(-32768, -32768, -32768, 32'd0, 63'd800001));
        send_sample(mk(0, 0, 0, 32'd0, 63'd900000));
        send_sample(mk(32767, 32767, 32767, 32'd0, 63'd100));
        send_sample(mk(0, 0, 0, 32'd0, 63'd50));
        send_sample(mk(-32768, -32768, -32768, 32'd0, 63'd60));
        send_sample(mk(1, -1, 2, 32'hFFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF));
        send_sample(mk(32767, -32768, 0, 32'hFFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF));
        send_sample(mk(-32768, 32767, -1, 32'hFFFF_FFFF, 63'd0));
        send_sample(mk(0, 0, 0, 32'h5555_5555, 63'h2AAA_AAAA_AAAA_AAAA));
        send_sample(mk(-1, -1, -1, 32'hAAAA_AAAA, 63'h1555_5555_5555_5555));
        send_sample(mk(32767, 32767, 32767, 32'hAAAA_AAAA, 63'h7555_5555_5555_5555));
        send_sample(mk(-32768, 0, 32767, 32'hAAAA_AAAA, 63'h7FFF_FFFF_FFFF_FFFF));
        send_sample(mk(0, 0, 1, 32'd0, 63'd0));
        send_sample(mk(0, 16384, 0, 32'd0, 63'd350000));
    endtask

    // Receiver: checks every result beat at the edge that takes it, then
    // picks the stall for the next cycle. A hold-off request makes it stall
    // for a long counted stretch so that the pipeline backs up into in_stall.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                board.check_report(step_total, current_day, step_seen);
            if (hold_left == 0 && hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 200;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !quiet && ($urandom_range(99) < 14);
            end
        end
    end

    // Main sequence: reset, directed samples, then eight phases of random
    // samples. The first two phases pin every register to an extreme; the
    // rest draw thresholds that let the walk count steps now and then.
    initial
    begin
        logic [LEVEL_W-1:0] trig;
        logic [LEVEL_W-1:0] rel;
        logic [LEVEL_W-1:0] gap;
        logic [SHIFT_W-1:0] fs;
        logic [SHIFT_W-1:0] ss;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        accel_x  = '0;
        accel_y  = '0;
        accel_z  = '0;
        day_key  = '0;
        time_us  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                // Zero trigger, full release and no gap: every rising signal
                // both clears the latch and counts in the same sample.
                0: set_levels('0, '1, '0, 4'd0, 4'd15);
                // Nothing can ever trigger, and the shifts are reversed.
                1: set_levels('1, '0, '1, 4'd15, 4'd0);
                default:
                begin
                    trig = ($urandom_range(3) == 0) ? $urandom_range(0, 1 << 26)
                                                    : $urandom_range(1000, 400000);
                    rel  = $urandom_range(0, trig);
                    gap  = $urandom_range(0, 500000);
                    fs   = SHIFT_W'($urandom_range(0, 4));
                    ss   = SHIFT_W'($urandom_range(fs + 1, 9));
                    set_levels(trig, rel, gap, fs, ss);
                end
            endcase
            quiet = (phase == 6);
            for (int n = 0; n < 166; n++)
            begin
                if (phase == 3 && n == 40)
                    hold_req = 1'b1;
                if (phase == 5 && n == 80)
                    wait_drained();
                send_sample(next_sample());
                // Keep offering back to back while the receiver holds off.
                if (!(phase == 3 && n >= 40 && n < 100))
                    sender_gaps();
            end
        end
        quiet = 1'b0;

        wait_drained();
        repeat (10) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("accel_step_detector_unit_test passed");
        else
            $display("accel_step_detector_unit_test failed");
        $finish;
    end

    // Far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("accel_step_detector_unit_test failed");
        $finish;
    end

endmodule
